// File: src/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types, codes and lookup tables of the hall rotor tracker.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int STAMP_W  = 16;
  localparam int POS_W    = 32;
  localparam int HALL_W   = 3;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 56;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  localparam logic [HALL_W-1:0]  HALL_LOW   = 3'b000;
  localparam logic [HALL_W-1:0]  HALL_HIGH  = 3'b111;
  localparam logic [STAMP_W-1:0] PERIOD_UNK = 16'hFFFF;

  typedef struct packed {
    logic [HALL_W-1:0]  last_hall;
    logic [1:0]         dir;
    logic [POS_W-1:0]   pos;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] last_stamp;
  } hrt_state_t;

  typedef struct packed {
    logic [STAMP_W-1:0] period;
    logic [POS_W-1:0]   position;
    logic [1:0]         direction;
    logic               hall_fault;
    logic [2:0]         sector;
  } hrt_result_t;

  // Next hall state in the forward sequence 1,3,2,6,4,5; the top bit flags a valid entry.
  function automatic logic [HALL_W:0] fwd_next(input logic [HALL_W-1:0] h);
    logic [HALL_W:0] r;
    unique case (h)
      3'd1:    r = {1'b1, 3'd3};
      3'd3:    r = {1'b1, 3'd2};
      3'd2:    r = {1'b1, 3'd6};
      3'd6:    r = {1'b1, 3'd4};
      3'd4:    r = {1'b1, 3'd5};
      3'd5:    r = {1'b1, 3'd1};
      default: r = {1'b0, 3'd0};
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sector_of(input logic [HALL_W-1:0] h);
    logic [2:0] s;
    unique case (h)
      3'd1:    s = 3'd0;
      3'd3:    s = 3'd1;
      3'd2:    s = 3'd2;
      3'd6:    s = 3'd3;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// File: src/hrt_core.sv
// ----------------------------------------------------------------------------
// hrt_core
// Next-state and result logic for one hall sample or clear request.
// ----------------------------------------------------------------------------
module hrt_core import hrt_pkg::*; (
  input  hrt_state_t          st,
  input  logic                mode,
  input  logic [HALL_W-1:0]   hall,
  input  logic [STAMP_W-1:0]  stamp,
  output hrt_state_t          st_nxt,
  output hrt_result_t         res
);

  logic            fault;
  logic [HALL_W:0] prev_next;
  logic [HALL_W:0] cur_next;
  logic            is_fwd;
  logic            is_rev;

  assign fault     = (hall == HALL_LOW) || (hall == HALL_HIGH);
  assign prev_next = fwd_next(st.last_hall);
  assign cur_next  = fwd_next(hall);
  assign is_fwd    = prev_next[HALL_W] && (prev_next[HALL_W-1:0] == hall);
  assign is_rev    = cur_next[HALL_W] && (cur_next[HALL_W-1:0] == st.last_hall);

  always_comb begin
    st_nxt = st;
    if (mode) begin
      st_nxt.pos = '0;
    end else if ((hall != st.last_hall) && !fault) begin
      if (is_fwd) begin
        st_nxt.dir = DIR_FWD;
        st_nxt.pos = st.pos + POS_W'(1);
      end else if (is_rev) begin
        st_nxt.dir = DIR_REV;
        st_nxt.pos = st.pos - POS_W'(1);
      end
      st_nxt.period     = stamp - st.last_stamp;
      st_nxt.last_stamp = stamp;
      st_nxt.last_hall  = hall;
    end
  end

  always_comb begin
    res.sector     = fault ? 3'd0 : sector_of(hall);
    res.hall_fault = fault;
    res.direction  = st_nxt.dir;
    res.position   = st_nxt.pos;
    res.period     = st_nxt.period;
  end

endmodule

// File: src/hall_rotor_tracker.sv
// ----------------------------------------------------------------------------
// hall_rotor_tracker
// Tracks sector, direction, position and period of a three-sensor hall rotor.
// ----------------------------------------------------------------------------
// Each request on the in_ channel is one hall sample with its timestamp, or,
// with in_tuser high, a clear of the position count. Every request yields
// exactly one result on the out_ channel, showing the tracker after the
// update. A request is registered on entry, then the tracker state and the
// result register are updated when it is processed, which waits while a
// held result is not taken. One request is taken every cycle while out_tready
// is high; the rate is set by the single state update per cycle.
// When the receiver holds out_tready low, the result waits in its register
// and one more request is held in the input register; in_tready then falls
// until the result is taken, and nothing is lost or repeated.
// Reset clears both registers, the position, direction and last hall state
// and last timestamp to zero, and sets the period to 65535 (unknown).
// ----------------------------------------------------------------------------
module hall_rotor_tracker import hrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // hall_a, hall_b, hall_c, timestamp[15:0], zero fill
  input  logic [IN_DW-1:0]  in_tdata,
  // mode
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // sector[2:0], hall_fault, direction[1:0], position[31:0], period[15:0], zero fill
  output logic [OUT_DW-1:0] out_tdata
);

  logic               in_vld_r;
  logic               in_mode_r;
  logic [HALL_W-1:0]  in_hall_r;
  logic [STAMP_W-1:0] in_stamp_r;
  hrt_state_t         state_r;
  hrt_state_t         state_nxt;
  hrt_result_t        res_nxt;
  logic               out_vld_r;
  hrt_result_t        out_res_r;
  logic               fire;
  logic               in_fire;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode_r  <= in_tuser;
      in_hall_r  <= in_tdata[HALL_W-1:0];
      in_stamp_r <= in_tdata[HALL_W+STAMP_W-1:HALL_W];
    end
  end

  hrt_core u_core (
    .st     (state_r),
    .mode   (in_mode_r),
    .hall   (in_hall_r),
    .stamp  (in_stamp_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_hall  <= HALL_LOW;
      state_r.dir        <= DIR_NONE;
      state_r.pos        <= '0;
      state_r.period     <= PERIOD_UNK;
      state_r.last_stamp <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DW - $bits(hrt_result_t)){1'b0}}, out_res_r};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full and stalled");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("tracker state changed without a request being processed");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("processed request produced no result");

endmodule
